// ===== rtl/ara_pkg.sv =====
`timescale 1ns / 1ps
package ara_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int NumBins   = 512;
    localparam int BinW      = $clog2(NumBins);
    localparam int PosW      = 8;
    localparam int SumW      = 48;
    localparam int CntW      = 17;
    localparam int RadW      = 32;
    localparam int RootW     = RadW / 2;
    localparam int DivW      = SumW;

    typedef enum logic [1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_ASPECT = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_DX, ST_DY, ST_SQ, ST_ROOT, ST_RD, ST_WR,
        ST_RRD, ST_RGET, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_unit_ctl;
endpackage

// ===== rtl/ara_isqrt.sv =====
`timescale 1ns / 1ps
module ara_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ara_pkg::t_unit_ctl          i_ctl,
    input  logic [ara_pkg::RadW-1:0]    i_value,
    output logic                        o_busy,
    output logic [ara_pkg::RootW-1:0]   o_root
);
    import ara_pkg::*;

    localparam int StepW = $clog2(RootW + 1);

    logic [RadW-1:0]  r_rem, n_rem;
    logic [RadW-1:0]  r_root, n_root;
    logic [RadW-1:0]  r_bit, n_bit;
    logic [StepW-1:0] r_step, n_step;
    logic             r_busy, n_busy;
    logic [RadW-1:0]  w_trial;

    assign w_trial = r_root + r_bit;

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        n_step = r_step;
        n_busy = r_busy;
        if (i_ctl.start) begin
            n_rem  = i_value;
            n_root = '0;
            n_bit  = {2'b01, {(RadW-2){1'b0}}};
            n_step = StepW'(RootW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= w_trial) begin
                n_rem  = r_rem - w_trial;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit  = r_bit >> 2;
            n_step = r_step - 1'b1;
            if (r_step == StepW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    assign o_busy = r_busy;
    assign o_root = r_root[RootW-1:0];
endmodule

// ===== rtl/ara_divider.sv =====
`timescale 1ns / 1ps
module ara_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ara_pkg::t_unit_ctl         i_ctl,
    input  logic [ara_pkg::DivW-1:0]   i_num,
    input  logic [ara_pkg::CntW-1:0]   i_den,
    output logic                       o_busy,
    output logic [ara_pkg::DivW-1:0]   o_quot
);
    import ara_pkg::*;

    localparam int StepW = $clog2(DivW + 1);

    logic [DivW-1:0]  r_quot, n_quot;
    logic [CntW:0]    r_rem, n_rem;
    logic [CntW-1:0]  r_den;
    logic [StepW-1:0] r_step, n_step;
    logic             r_busy, n_busy;
    logic [CntW:0]    w_shift;

    assign w_shift = {r_rem[CntW-1:0], r_quot[DivW-1]};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        if (i_ctl.start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_step = StepW'(DivW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem  = w_shift - {1'b0, r_den};
                n_quot = {r_quot[DivW-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[DivW-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == StepW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_ctl.start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

// ===== rtl/azimuthal_radial_average.sv =====
`timescale 1ns / 1ps
// Radial average of a centered power spectrum. Pixel items arrive in raster order and the
// block keeps the column and row itself. A pixel item passes through the setup states ST_DX,
// ST_DY and ST_SQ, the 16-step square-root unit, then a read and a write of the bin memory.
// A read item fetches the bin and runs the 48-step serial divider for the mean, and waits
// while an earlier result has not been taken. A new item is taken only from idle. A clear
// item sweeps the 512-entry bin memory at one entry a cycle; after reset the same clearing
// pass runs before the first item is taken.
module azimuthal_radial_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pixel_value[31:0], bin_index[40:32], zeros
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // bin_mean, bin_count, bin_empty, highest_bin, zeros
    output logic        m_axis_tlast,  // last_bin
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import ara_pkg::*;

    t_state r_state, n_state;
    logic [8:0]  r_width, r_height;
    logic [10:0] r_aspect;
    logic [PosW-1:0] r_col, r_row;
    logic [BinW-1:0] r_max;
    logic [BinW-1:0] r_addr;
    logic [31:0] r_val;
    logic [BinW:0] r_idx;
    logic [PosW-1:0] r_adx, r_ady;
    logic [CntW-1:0] r_cnt;
    logic [31:0] r_mean;
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_olast;

    logic [SumW+CntW-1:0] mem [NumBins];
    logic [SumW+CntW-1:0] r_rdata;

    logic [8:0] w_w, w_h;
    logic [PosW-1:0] w_cx, w_cy;
    t_unit_ctl w_sq_ctl, w_dv_ctl;
    logic w_sq_busy, w_dv_busy;
    logic [RootW-1:0] w_root;
    logic [DivW-1:0]  w_quot;
    logic [RootW:0]   w_bin;
    logic [BinW-1:0]  w_b;
    logic [SumW:0]    w_sadd;
    logic             w_take;
    logic [RadW-1:0]  w_rad;

    assign w_w  = (r_width == 9'd0) ? 9'd1 : (r_width > 9'(MaxWidth)) ? 9'(MaxWidth) : r_width;
    assign w_h  = (r_height == 9'd0) ? 9'd1
                : (r_height > 9'(MaxHeight)) ? 9'(MaxHeight) : r_height;
    assign w_cx = PosW'(w_w >> 1);
    assign w_cy = PosW'(w_h >> 1);
    assign w_bin = ({1'b0, w_root} + 1'b1) >> 1;
    assign w_b   = (w_bin > (RootW+1)'(NumBins-1)) ? BinW'(NumBins-1) : BinW'(w_bin);
    assign w_sadd = {1'b0, r_rdata[SumW+CntW-1:CntW]} + (SumW+1)'(r_val);
    assign w_take = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (t_func'(s_axis_tuser))
                        FUNC_PIXEL: n_state = ST_DX;
                        FUNC_READ:  n_state = ST_RRD;
                        FUNC_CLEAR: n_state = ST_CLR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:  if (r_addr == BinW'(NumBins-1)) n_state = ST_IDLE;
            ST_DX:   n_state = ST_DY;
            ST_DY:   n_state = ST_SQ;
            ST_SQ:   n_state = ST_ROOT;
            ST_ROOT: if (!w_sq_busy) n_state = ST_RD;
            ST_RD:   n_state = ST_WR;
            ST_WR:   n_state = ST_IDLE;
            ST_RRD:  n_state = ST_RGET;
            ST_RGET: n_state = ST_DIV;
            ST_DIV:  if (!w_dv_busy) n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_sq_ctl = '{start: (r_state == ST_SQ), busy: 1'b0};
        w_dv_ctl = '{start: (r_state == ST_RGET), busy: 1'b0};
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    ara_isqrt u_sqrt (
        .i_clk, .i_rst_n, .i_ctl(w_sq_ctl),
        .i_value(w_rad), .o_busy(w_sq_busy), .o_root(w_root)
    );

    ara_divider u_div (
        .i_clk, .i_rst_n, .i_ctl(w_dv_ctl),
        .i_num(r_rdata[SumW+CntW-1:CntW]), .i_den(r_rdata[CntW-1:0]),
        .o_busy(w_dv_busy), .o_quot(w_quot)
    );

    logic [2*PosW-1:0]      w_dx2;
    logic [PosW+11-1:0]     r_ry;
    logic [2*(PosW+11)-1:0] w_ry2;
    logic [2*(PosW+11):0]   w_r;
    assign w_dx2 = r_adx * r_adx;
    assign w_ry2 = r_ry * r_ry;
    assign w_r   = (2*(PosW+11)+1)'({w_dx2, 16'b0}) + (2*(PosW+11)+1)'(w_ry2);
    assign w_rad = RadW'(w_r >> 14);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD || r_state == ST_RRD) begin
            r_rdata <= mem[r_addr];
        end
        if (r_state == ST_CLR) begin
            mem[r_addr] <= '0;
        end else if (r_state == ST_WR) begin
            mem[r_addr] <= {w_sadd[SumW] ? {SumW{1'b1}} : w_sadd[SumW-1:0],
                            (&r_rdata[CntW-1:0]) ? r_rdata[CntW-1:0]
                                                 : r_rdata[CntW-1:0] + 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_addr   <= '0;
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_aspect <= 11'd256;
            r_col    <= '0;
            r_row    <= '0;
            r_max    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:  r_width  <= i_cfg_data[8:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[8:0];
                    CFG_ASPECT: r_aspect <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take && t_func'(s_axis_tuser) == FUNC_CLEAR) begin
                        r_addr <= '0;
                        r_col  <= '0;
                        r_row  <= '0;
                        r_max  <= '0;
                    end
                end
                ST_CLR: r_addr <= r_addr + 1'b1;
                ST_ROOT: if (!w_sq_busy) r_addr <= w_b;
                ST_WR: begin
                    if (r_addr > r_max) r_max <= r_addr;
                    if (9'(r_col) + 9'd1 >= w_w) begin
                        r_col <= '0;
                        r_row <= (9'(r_row) + 9'd1 >= w_h) ? '0 : r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_RRD: ;
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (w_take) begin
            r_val  <= s_axis_tdata[31:0];
            r_idx  <= {1'b0, s_axis_tdata[40:32]};
            if (r_state == ST_IDLE && t_func'(s_axis_tuser) == FUNC_READ) begin
                r_addr <= s_axis_tdata[40:32];
            end
        end
        if (r_state == ST_DX) begin
            r_adx <= (r_col >= w_cx) ? r_col - w_cx : w_cx - r_col;
            r_ady <= (r_row >= w_cy) ? r_row - w_cy : w_cy - r_row;
        end
        if (r_state == ST_DY) r_ry <= r_ady * r_aspect;
        if (r_state == ST_RGET) begin
            r_cnt <= r_rdata[CntW-1:0];
        end
        if (r_state == ST_DIV && !w_dv_busy) begin
            r_mean <= (r_cnt == '0) ? 32'd0
                    : (|w_quot[DivW-1:32]) ? 32'hFFFF_FFFF : w_quot[31:0];
        end
        if (r_state == ST_OUT && !r_ovalid) begin
            r_odata <= {5'b0, r_max, (r_cnt == '0), r_cnt, r_mean};
            r_olast <= (r_idx[BinW-1:0] == r_max);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |=> w_sq_busy)
        else $error("root unit did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RGET) |=> w_dv_busy)
        else $error("divider did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sq_busy && !w_dv_busy)
        else $error("ready while a unit is busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |=> (r_max >= $past(r_addr)))
        else $error("highest bin lost");
endmodule
